// ===== hw/rtl/gsp_pkg.sv =====
// Shared constants, opcodes, controller states and control/status bundles.
package gsp_pkg;

	localparam int MAX_NODES   = 64;
	localparam int NODE_BITS   = $clog2(MAX_NODES);
	localparam int CNT_BITS    = $clog2(MAX_NODES + 1);
	localparam int WEIGHT_BITS = 16;
	localparam int DIST_BITS   = 22;
	localparam int EADDR_BITS  = 2 * NODE_BITS;
	localparam int EDGE_DEPTH  = MAX_NODES * MAX_NODES;

	typedef enum logic {
		OP_EDGE  = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EDGE_RD,
		ST_EDGE_CHK,
		ST_EDGE_WR2,
		ST_Q_CHK,
		ST_TRIV,
		ST_Q_INIT,
		ST_ROW,
		ST_REL_START,
		ST_REL,
		ST_NEXT,
		ST_RES_RD,
		ST_RES
	} state_t;

	typedef struct packed {
		logic clr_step;
		logic load_item;
		logic edge_wr_ab;
		logic edge_wr_ba;
		logic q_init;
		logic row_rd;
		logic rel_start;
		logic rel_step;
		logic u_next;
		logic round_next;
		logic out_triv;
		logic out_res;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic edge_upd;
		logic q_bad;
		logic q_same;
		logic u_chg;
		logic u_last;
		logic v_more;
		logic nxt_any;
		logic out_free;
	} sts_t;

endpackage

// ===== hw/rtl/gsp_ctrl.sv =====
// Sequencing FSM: edge-memory clear, edge insert, query checks, relaxation rounds and result output.
module gsp_ctrl
	import gsp_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	input  logic   opcode,
	input  sts_t   sts,
	output logic   in_stall,
	output cmd_t   cmd,
	output state_t state
);

	state_t state_q, state_nxt;
	logic   acc;

	assign state = state_q;
	assign acc   = (state_q == ST_IDLE) && in_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_stall  = (state_q != ST_IDLE);
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) state_nxt = ST_IDLE;
			end
			ST_IDLE: begin
				if (acc) begin
					cmd.load_item = 1'b1;
					state_nxt = (op_t'(opcode) == OP_QUERY) ? ST_Q_CHK : ST_EDGE_RD;
				end
			end
			ST_EDGE_RD: state_nxt = ST_EDGE_CHK;
			ST_EDGE_CHK: begin
				if (sts.edge_upd) begin
					cmd.edge_wr_ab = 1'b1;
					state_nxt = ST_EDGE_WR2;
				end else begin
					state_nxt = ST_IDLE;
				end
			end
			ST_EDGE_WR2: begin
				cmd.edge_wr_ba = 1'b1;
				state_nxt = ST_IDLE;
			end
			ST_Q_CHK: begin
				state_nxt = (sts.q_bad || sts.q_same) ? ST_TRIV : ST_Q_INIT;
			end
			ST_TRIV: begin
				if (sts.out_free) begin
					cmd.out_triv = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			ST_Q_INIT: begin
				cmd.q_init = 1'b1;
				state_nxt = ST_ROW;
			end
			ST_ROW: begin
				if (sts.u_chg) begin
					cmd.row_rd = 1'b1;
					state_nxt = ST_REL_START;
				end else begin
					state_nxt = ST_NEXT;
				end
			end
			ST_REL_START: begin
				cmd.rel_start = 1'b1;
				state_nxt = ST_REL;
			end
			ST_REL: begin
				cmd.rel_step = 1'b1;
				if (!sts.v_more) state_nxt = ST_NEXT;
			end
			ST_NEXT: begin
				if (!sts.u_last) begin
					cmd.u_next = 1'b1;
					state_nxt = ST_ROW;
				end else if (sts.nxt_any) begin
					cmd.round_next = 1'b1;
					state_nxt = ST_ROW;
				end else begin
					state_nxt = ST_RES_RD;
				end
			end
			ST_RES_RD: state_nxt = ST_RES;
			ST_RES: begin
				if (sts.out_free) begin
					cmd.out_res = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

endmodule

// ===== hw/rtl/gsp_dpath.sv =====
// Datapath: adjacency and distance memories, node flags, relax unit, result register.
module gsp_dpath
	import gsp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	output sts_t                 sts,
	input  logic                 cfg_we,
	input  logic [CNT_BITS-1:0]  cfg_data,
	input  logic [NODE_BITS-1:0] node_a,
	input  logic [NODE_BITS-1:0] node_b,
	input  logic [15:0]          weight,
	input  logic                 out_stall,
	output logic                 out_valid,
	output logic [DIST_BITS-1:0] distance,
	output logic                 reachable
);

	logic [CNT_BITS-1:0]    nc_q, n_eff;
	logic [NODE_BITS-1:0]   a_q, b_q, u_q, pv_q;
	logic [WEIGHT_BITS-1:0] w_q;
	logic [CNT_BITS-1:0]    v_q;
	logic [EADDR_BITS-1:0]  clr_q;
	logic [MAX_NODES-1:0]   reached_q, chg_q, nxt_q;
	logic                   pend_q;
	logic [DIST_BITS-1:0]   du_q;

	logic                   out_valid_q, reach_out_q;
	logic [DIST_BITS-1:0]   dist_out_q;

	// adjacency memory
	logic [WEIGHT_BITS-1:0] edge_mem [EDGE_DEPTH];
	logic [WEIGHT_BITS-1:0] erd_q, ewd;
	logic [EADDR_BITS-1:0]  era, ewa;
	logic                   ewe;

	// distance memory
	logic [DIST_BITS-1:0]   dist_mem [MAX_NODES];
	logic [DIST_BITS-1:0]   drd_q, dwd;
	logic [NODE_BITS-1:0]   dra, dwa;
	logic                   dwe;

	logic [DIST_BITS:0]     sum;
	logic [DIST_BITS-1:0]   cand;
	logic                   upd;

	always_comb begin
		if (nc_q == '0) n_eff = CNT_BITS'(1);
		else if (nc_q > CNT_BITS'(MAX_NODES)) n_eff = CNT_BITS'(MAX_NODES);
		else n_eff = nc_q;
	end

	assign sum  = {1'b0, du_q} + (DIST_BITS + 1)'(erd_q);
	assign cand = sum[DIST_BITS] ? '1 : sum[DIST_BITS-1:0];
	assign upd  = cmd.rel_step && pend_q && (erd_q != '0) && (pv_q != a_q)
		&& (!reached_q[pv_q] || (cand < drd_q));

	// read and write addresses
	always_comb begin
		era = {a_q, b_q};
		dra = b_q;
		if (cmd.row_rd) dra = u_q;
		if (cmd.rel_start) begin
			era = {u_q, NODE_BITS'(0)};
			dra = '0;
		end
		if (cmd.rel_step) begin
			era = {u_q, v_q[NODE_BITS-1:0]};
			dra = v_q[NODE_BITS-1:0];
		end
		ewe = cmd.clr_step || cmd.edge_wr_ab || cmd.edge_wr_ba;
		ewa = cmd.clr_step ? clr_q : (cmd.edge_wr_ba ? {b_q, a_q} : {a_q, b_q});
		ewd = cmd.clr_step ? '0 : w_q;
		dwe = cmd.q_init || upd;
		dwa = cmd.q_init ? a_q : pv_q;
		dwd = cmd.q_init ? '0 : cand;
	end

	always_ff @(posedge clk) begin
		if (ewe) edge_mem[ewa] <= ewd;
		erd_q <= edge_mem[era];
	end

	always_ff @(posedge clk) begin
		if (dwe) dist_mem[dwa] <= dwd;
		drd_q <= dist_mem[dra];
	end

	// payload, row distance and result registers
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			a_q <= node_a;
			b_q <= node_b;
			w_q <= WEIGHT_BITS'(weight);
		end
		if (cmd.rel_start) du_q <= drd_q;
		if (cmd.out_triv) dist_out_q <= '0;
		if (cmd.out_res) dist_out_q <= reached_q[b_q] ? drd_q : '0;
		if (cmd.out_triv) reach_out_q <= !sts.q_bad;
		if (cmd.out_res) reach_out_q <= reached_q[b_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nc_q        <= CNT_BITS'(MAX_NODES);
			clr_q       <= '0;
			u_q         <= '0;
			v_q         <= '0;
			pv_q        <= '0;
			pend_q      <= 1'b0;
			reached_q   <= '0;
			chg_q       <= '0;
			nxt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) nc_q <= cfg_data;
			if (cmd.clr_step) clr_q <= clr_q + EADDR_BITS'(1);
			if (cmd.q_init) begin
				reached_q <= MAX_NODES'(1) << a_q;
				chg_q     <= MAX_NODES'(1) << a_q;
				nxt_q     <= '0;
				u_q       <= '0;
			end
			if (cmd.row_rd) v_q <= '0;
			if (cmd.rel_start) begin
				pv_q   <= '0;
				v_q    <= CNT_BITS'(1);
				pend_q <= 1'b1;
			end
			if (cmd.rel_step) begin
				if (sts.v_more) begin
					pv_q <= v_q[NODE_BITS-1:0];
					v_q  <= v_q + CNT_BITS'(1);
				end else begin
					pend_q <= 1'b0;
				end
			end
			if (upd) begin
				reached_q[pv_q] <= 1'b1;
				nxt_q[pv_q]     <= 1'b1;
			end
			if (cmd.u_next) u_q <= u_q + NODE_BITS'(1);
			if (cmd.round_next) begin
				chg_q <= nxt_q;
				nxt_q <= '0;
				u_q   <= '0;
			end
			if (cmd.out_triv || cmd.out_res) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		sts.clr_last = (clr_q == '1);
		sts.edge_upd = (w_q != '0) && (CNT_BITS'(a_q) < n_eff) && (CNT_BITS'(b_q) < n_eff)
			&& ((erd_q == '0) || (erd_q > w_q));
		sts.q_bad    = (CNT_BITS'(a_q) >= n_eff) || (CNT_BITS'(b_q) >= n_eff);
		sts.q_same   = (a_q == b_q);
		sts.u_chg    = chg_q[u_q];
		sts.u_last   = (CNT_BITS'(u_q) + CNT_BITS'(1)) == n_eff;
		sts.v_more   = (v_q < n_eff);
		sts.nxt_any  = (nxt_q != '0);
		sts.out_free = !out_valid_q || !out_stall;
	end

	assign out_valid = out_valid_q;
	assign distance  = dist_out_q;
	assign reachable = reach_out_q;

endmodule

// ===== hw/rtl/graph_shortest_path.sv =====
// Top level: single-pair shortest path over a stored undirected weighted graph.
// Use:
//  - Input channel (in_valid/in_stall): opcode 0 stores edge node_a-node_b with
//    weight (0 = no edge, a repeat keeps the smaller weight); opcode 1 queries
//    the path from node_a to node_b. Edge items give no result.
//  - Output channel (out_valid/out_stall): one transfer per query, distance
//    and reachable. Unreachable or out-of-range gives 0; same node gives 0, 1.
//  - Config channel (cfg_valid/cfg_ready): node_count, always ready; write only
//    while idle. 0 acts as 1, values above 64 act as 64.
// Sequence: an edge item is read, compared and, on an update, written twice,
// mirrored, on the one adjacency write port. A query is checked; unless it is
// trivial, each relaxation round then visits every node row and relaxes each
// row whose node changed against all nodes; rounds repeat until no distance
// moves (at most n rounds). The single adjacency read port gives one entry a cycle.
// Reset: node flags and the output clear at once; the 4096-entry adjacency
// memory is then swept to zero, one entry a cycle, with in_stall high.
// Stall: a finished result waits in the output register; the next item is
// still taken, and a following query holds in its last state until it frees.
module graph_shortest_path
	import gsp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 opcode,
	input  logic [NODE_BITS-1:0] node_a,
	input  logic [NODE_BITS-1:0] node_b,
	input  logic [15:0]          weight,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [DIST_BITS-1:0] distance,
	output logic                 reachable,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CNT_BITS-1:0]  cfg_data
);

	cmd_t   cmd;
	sts_t   sts;
	state_t state;

	assign cfg_ready = 1'b1;

	gsp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.opcode   (opcode),
		.sts      (sts),
		.in_stall (in_stall),
		.cmd      (cmd),
		.state    (state)
	);

	gsp_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.node_a    (node_a),
		.node_b    (node_b),
		.weight    (weight),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.distance  (distance),
		.reachable (reachable)
	);

	// no item taken during the clearing sweep
	a_clear_stall: assert property (@(posedge clk) disable iff (!arst_n)
		state == ST_CLEAR |-> in_stall)
		else $error("item taken during clear");

	// a result only appears from a result state
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> ($past(state) == ST_RES || $past(state) == ST_TRIV))
		else $error("unexpected result transfer");

	// nonzero distance only for a reached node
	a_dist_reach: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (distance != '0) |-> reachable)
		else $error("distance without reachable");

endmodule

// ===== tb/sv/testbench.sv =====
// Testbench for graph_shortest_path: edge loads and queries against a behavioural model.
`timescale 1ns / 100ps

module testbench
	import gsp_pkg::*;
();

	localparam int WATCHDOG_LIMIT = 2000000;
	localparam logic [21:0] DIST_SAT = 22'h3FFFFF;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic                 opcode;
	logic [NODE_BITS-1:0] node_a;
	logic [NODE_BITS-1:0] node_b;
	logic [15:0]          weight;
	logic                 out_valid;
	logic                 out_stall;
	logic [DIST_BITS-1:0] distance;
	logic                 reachable;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CNT_BITS-1:0]  cfg_data;

	graph_shortest_path dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .node_a(node_a), .node_b(node_b), .weight(weight),
		.out_valid(out_valid), .out_stall(out_stall),
		.distance(distance), .reachable(reachable),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// Behavioural copy of the graph and its setting
	logic [15:0] adj_weight [MAX_NODES][MAX_NODES];
	logic [6:0]  nodes_in_use;

	typedef struct {
		logic [DIST_BITS-1:0] dist_val;
		logic                 reach;
	} path_result_t;

	path_result_t pending_paths[$];

	int error_count = 0;
	int queries_sent;
	int edges_sent;
	int paths_checked = 0;
	int idle_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Gap length: mostly zero or short, now and then long
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	function automatic int active_nodes();
		if (nodes_in_use < 1)
			return 1;
		if (nodes_in_use > MAX_NODES)
			return MAX_NODES;
		return nodes_in_use;
	endfunction

	function automatic logic [21:0] sum_sat(logic [21:0] d, logic [15:0] w);
		logic [22:0] s;
		s = {1'b0, d} + w;
		return (s > DIST_SAT) ? DIST_SAT : s[21:0];
	endfunction

	// Relax from the source until no distance moves
	function automatic path_result_t shortest_path(int src, int dst);
		path_result_t res;
		logic [21:0] node_dist [MAX_NODES];
		bit reached [MAX_NODES];
		bit moved [MAX_NODES];
		bit moved_next [MAX_NODES];
		bit any;
		int n;
		logic [21:0] cand;
		n = active_nodes();
		if (src >= n || dst >= n) begin
			res.dist_val = '0;
			res.reach = 1'b0;
			return res;
		end
		if (src == dst) begin
			res.dist_val = '0;
			res.reach = 1'b1;
			return res;
		end
		for (int i = 0; i < MAX_NODES; i++) begin
			node_dist[i] = '0;
			reached[i] = 1'b0;
			moved[i] = 1'b0;
		end
		reached[src] = 1'b1;
		moved[src] = 1'b1;
		any = 1'b1;
		for (int round = 0; round <= MAX_NODES && any; round++) begin
			any = 1'b0;
			for (int i = 0; i < MAX_NODES; i++)
				moved_next[i] = 1'b0;
			for (int u = 0; u < n; u++) begin
				if (!moved[u])
					continue;
				for (int v = 0; v < n; v++) begin
					if (adj_weight[u][v] == 0 || v == src)
						continue;
					cand = sum_sat(node_dist[u], adj_weight[u][v]);
					if (!reached[v] || cand < node_dist[v]) begin
						reached[v] = 1'b1;
						node_dist[v] = cand;
						moved_next[v] = 1'b1;
						any = 1'b1;
					end
				end
			end
			moved = moved_next;
		end
		res.reach = reached[dst];
		res.dist_val = reached[dst] ? node_dist[dst] : '0;
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		error_count++;
		$display("MISMATCH @%0t: %s", $time, msg);
	endtask

	// Send one item; the model is updated when the transfer happens.
	// Valid stays high after a transfer unless a gap follows.
	task automatic send_item(input op_t op, input int a, input int b, input int w);
		int n;
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode   <= op;
		node_a   <= a[NODE_BITS-1:0];
		node_b   <= b[NODE_BITS-1:0];
		weight   <= w[15:0];
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		n = active_nodes();
		if (op == OP_EDGE) begin
			edges_sent++;
			if (w[15:0] != 0 && a < n && b < n &&
			    (adj_weight[a][b] == 0 || adj_weight[a][b] > w[15:0])) begin
				adj_weight[a][b] = w[15:0];
				adj_weight[b][a] = w[15:0];
			end
		end else begin
			queries_sent++;
			pending_paths.insert(pending_paths.size(), shortest_path(a, b));
		end
	endtask

	// Wait for outstanding results, then let a trailing edge load finish
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_paths.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_node_count(input int value);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= value[CNT_BITS-1:0];
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		nodes_in_use = value[6:0];
	endtask

	// Random stall on the result side
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 3) == 0)
				out_stall <= 1'b1;
			else if (out_stall && $urandom_range(0, 9) < 2) begin
				repeat ($urandom_range(5, 30)) @(posedge clk);
				out_stall <= 1'b0;
			end else
				out_stall <= 1'b0;
		end
	end

	// Result checker: compare each transfer with the oldest expectation
	always @(posedge clk) begin
		path_result_t exp_res;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_paths.size() == 0)
				report_mismatch("result transfer with nothing outstanding");
			else begin
				exp_res = pending_paths.pop_front();
				paths_checked++;
				if (distance !== exp_res.dist_val)
					report_mismatch($sformatf("distance got %0d want %0d",
						distance, exp_res.dist_val));
				if (reachable !== exp_res.reach)
					report_mismatch($sformatf("reachable got %0b want %0b",
						reachable, exp_res.reach));
			end
		end
	end

	// Watchdog: count cycles with no transfer on any channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
		    (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
			$display("Verification failed");
			$finish;
		end
	end

	// Extremes of weight, repeats, zero weight, self loop, same-node and unreachable queries
	task automatic test_directed_edges_and_queries();
		send_item(OP_EDGE, 0, 63, 16'hFFFF);
		send_item(OP_EDGE, 63, 0, 16'h0005);
		send_item(OP_EDGE, 0, 63, 16'h0009);
		send_item(OP_EDGE, 1, 2, 0);
		send_item(OP_EDGE, 5, 5, 3);
		send_item(OP_EDGE, 2, 42, 16'h5555);
		send_item(OP_EDGE, 42, 21, 16'hAAAA);
		send_item(OP_QUERY, 0, 63, 0);
		send_item(OP_QUERY, 63, 0, 16'hFFFF);
		send_item(OP_QUERY, 7, 7, 0);
		send_item(OP_QUERY, 2, 21, 0);
		send_item(OP_QUERY, 0, 1, 0);
		send_item(OP_QUERY, 5, 6, 0);
	endtask

	// Small node count: out-of-range edges and queries
	task automatic test_node_count_limits();
		write_node_count(0);
		send_item(OP_EDGE, 0, 1, 4);
		send_item(OP_QUERY, 0, 0, 0);
		send_item(OP_QUERY, 0, 1, 0);
		write_node_count(4);
		send_item(OP_EDGE, 1, 3, 7);
		send_item(OP_EDGE, 3, 4, 7);
		send_item(OP_QUERY, 1, 3, 0);
		send_item(OP_QUERY, 4, 1, 0);
		send_item(OP_QUERY, 3, 63, 0);
	endtask

	// Long chain of heavy edges towards the largest distances
	task automatic test_saturation();
		write_node_count(127);
		for (int i = 10; i < 76 && i < 63; i++)
			send_item(OP_EDGE, i, i + 1, 16'hFFFF);
		send_item(OP_QUERY, 10, 63, 0);
		send_item(OP_QUERY, 63, 30, 0);
	endtask

	// Random graphs: clustered well-formed loads and queries, some noise
	task automatic test_random_graph(input int count, input int nodes);
		int a, b, w, r;
		write_node_count(nodes);
		for (int k = 0; k < count; k++) begin
			r = $urandom_range(0, 99);
			a = $urandom_range(0, nodes - 1);
			b = $urandom_range(0, nodes - 1);
			if (r < 10) begin
				a = $urandom_range(0, 63);
				b = $urandom_range(0, 63);
			end
			w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 16'hFFFF)
				: $urandom_range(0, 40);
			if (r < 60)
				send_item(OP_EDGE, a, b, w);
			else
				send_item(OP_QUERY, a, b, $urandom_range(0, 16'hFFFF));
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		opcode    = OP_EDGE;
		node_a    = '0;
		node_b    = '0;
		weight    = '0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		queries_sent = 0;
		edges_sent = 0;
		nodes_in_use = 7'd64;
		for (int i = 0; i < MAX_NODES; i++)
			for (int j = 0; j < MAX_NODES; j++)
				adj_weight[i][j] = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		test_directed_edges_and_queries();
		test_node_count_limits();
		test_saturation();
		test_random_graph(25, 8);
		test_random_graph(25, 16);
		test_random_graph(20, 64);

		drain();
		$display("Covered %0d edge loads and %0d queries, %0d results checked",
			edges_sent, queries_sent, paths_checked);
		$display("Node counts 0, 4, 8, 16, 64 and 127 exercised");
		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
